/* rtl/tac_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and constants of the thermocouple averaging and calibration
// core: request kinds, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tac_pkg;

	// Request kinds on the input channel
	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_READ    = 2'd1,
		KIND_ZERO    = 2'd2,
		KIND_HUNDRED = 2'd3
	} kind_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SMP_UPD,
		ST_RD_MUL0,
		ST_RD_SAT0,
		ST_RD_MUL1,
		ST_RD_SAT1,
		ST_CAP_ZERO,
		ST_CAP_DIFF,
		ST_DIV_WAIT,
		ST_RESP
	} state_t;

	// Fixed-point format of the gain and result
	localparam int Q_FRAC    = 24;
	localparam int GAIN_W    = 32;
	localparam int TEMP_W    = 16;
	localparam int HUNDRED_W = 31;
	localparam logic [HUNDRED_W-1:0] HUNDRED_Q = HUNDRED_W'(100 << Q_FRAC);
	localparam logic [TEMP_W-1:0]    TEMP_MAX  = {TEMP_W{1'b1}};

	// Controller to datapath
	typedef struct packed {
		logic load;        // take request payload, read ring at pointer
		logic smp_upd;     // write ring, update running sums
		logic mul;         // multiply (avg - offset) by gain
		logic sat;         // saturate product into temperature
		logic rd_ch;       // channel of the read phase
		logic cap_sel;     // use the request channel for captures
		logic cap_zero;    // store offset, clear calibrated mark
		logic div_start;   // launch gain division
		logic gain_write;  // store quotient as gain
		logic reject;      // flag equal readings
		logic out_load;    // move result into output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic diff_zero;
		logic div_done;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/tac_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tac_div
// Restoring unsigned divider, one quotient bit per cycle. Pulses done in the
// cycle after the last step, with the quotient valid on quotient.
// ----------------------------------------------------------------------------
module tac_div import tac_pkg::*; #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] work_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             ge;

	// Trial subtract of the shifted remainder
	always_comb begin
		shifted = {rem_q, work_q[DVD_W-1]};
		trial   = shifted - {1'b0, dvs_q};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DVD_W-2:0], ge};
			rem_q  <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

`default_nettype wire

/* rtl/tac_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tac_datapath
// Sample ring, running sums, calibration registers, shared multiplier and
// saturation, gain divider and the result register.
// ----------------------------------------------------------------------------
module tac_datapath import tac_pkg::*; #(
	parameter int WINDOW      = 64,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	output stat_t                       st,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_data,
	input  wire logic                   channel,
	input  wire logic [SAMPLE_BITS-1:0] sample_first,
	input  wire logic [SAMPLE_BITS-1:0] sample_second,
	output logic [TEMP_W-1:0]           temp_first,
	output logic [TEMP_W-1:0]           temp_second,
	output logic                        status
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
	localparam int SHIFT  = $clog2(WINDOW + 1) - 1;
	localparam int AVG_W  = SUM_W - SHIFT;
	localparam int DIFF_W = AVG_W + 1;
	localparam int PROD_W = DIFF_W + GAIN_W;
	localparam int T_W    = PROD_W - Q_FRAC;

	// Ring storage, one pair per entry
	logic [2*SAMPLE_BITS-1:0] ring_mem [WINDOW];
	logic [2*SAMPLE_BITS-1:0] ring_rd_q;
	logic [PTR_W-1:0]         ptr_q;
	logic                     wrapped_q;

	logic [SUM_W-1:0]         sum_first_q;
	logic [SUM_W-1:0]         sum_second_q;
	logic                     single_q;

	logic                     chan_q;
	logic [SAMPLE_BITS-1:0]   smp_a_q;
	logic [SAMPLE_BITS-1:0]   smp_b_q;

	logic [AVG_W-1:0]         offset_q [2];
	logic signed [GAIN_W-1:0] gain_q [2];
	logic [1:0]               valid_q;
	logic                     neg_q;

	logic signed [PROD_W-1:0] prod_s1;
	logic [TEMP_W-1:0]        temp0_q;
	logic [TEMP_W-1:0]        temp1_q;
	logic                     reject_q;
	logic [TEMP_W-1:0]        out_first_q;
	logic [TEMP_W-1:0]        out_second_q;
	logic                     out_status_q;

	logic [SAMPLE_BITS-1:0]   old_a;
	logic [SAMPLE_BITS-1:0]   old_b;
	logic                     sel_ch;
	logic [AVG_W-1:0]         avg_first;
	logic [AVG_W-1:0]         avg_second;
	logic [AVG_W-1:0]         avg_sel;
	logic signed [DIFF_W-1:0] diff_cur;
	logic [AVG_W-1:0]         diff_mag;
	logic [T_W-1:0]           prod_hi;
	logic [TEMP_W-1:0]        sat_val;
	logic                     div_done;
	logic [HUNDRED_W-1:0]     div_q;

	// Averages and the difference against the stored offset
	always_comb begin
		old_a      = wrapped_q ? ring_rd_q[SAMPLE_BITS-1:0] : '0;
		old_b      = wrapped_q ? ring_rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
		sel_ch     = cmd.cap_sel ? chan_q : cmd.rd_ch;
		avg_first  = AVG_W'(sum_first_q >> SHIFT);
		avg_second = AVG_W'(sum_second_q >> SHIFT);
		avg_sel    = (!sel_ch || single_q) ? avg_first : avg_second;
		diff_cur   = $signed({1'b0, avg_sel}) - $signed({1'b0, offset_q[sel_ch]});
		diff_mag   = diff_cur[DIFF_W-1] ? AVG_W'(-diff_cur) : AVG_W'(diff_cur);
	end

	// Truncate product toward zero, clamp to the result range
	always_comb begin
		prod_hi = prod_s1[PROD_W-1:Q_FRAC];
		if (!valid_q[sel_ch]) begin
			sat_val = TEMP_W'(avg_sel);
		end else if (prod_s1[PROD_W-1]) begin
			sat_val = '0;
		end else if (prod_hi > T_W'(TEMP_MAX)) begin
			sat_val = TEMP_MAX;
		end else begin
			sat_val = prod_hi[TEMP_W-1:0];
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q <= 1'b0;
		end else if (cfg_valid) begin
			single_q <= cfg_data;
		end
	end

	// Ring memory: read at accept, write on update
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_rd_q <= ring_mem[ptr_q];
		end
		if (cmd.smp_upd) begin
			ring_mem[ptr_q] <= {smp_b_q, smp_a_q};
		end
	end

	// Latch request payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chan_q  <= channel;
			smp_a_q <= sample_first;
			smp_b_q <= sample_second;
		end
	end

	// Advance pointer, fill mark and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			wrapped_q    <= 1'b0;
			sum_first_q  <= '0;
			sum_second_q <= '0;
		end else if (cmd.smp_upd) begin
			sum_first_q  <= sum_first_q - SUM_W'(old_a) + SUM_W'(smp_a_q);
			sum_second_q <= sum_second_q - SUM_W'(old_b) + SUM_W'(smp_b_q);
			if (ptr_q == PTR_W'(WINDOW - 1)) begin
				ptr_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q[0] <= '0;
			offset_q[1] <= '0;
			gain_q[0]   <= '0;
			gain_q[1]   <= '0;
			valid_q     <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (cmd.cap_zero) begin
				offset_q[chan_q] <= avg_sel;
				valid_q[chan_q]  <= 1'b0;
			end
			if (cmd.div_start) begin
				neg_q <= diff_cur[DIFF_W-1];
			end
			if (cmd.gain_write) begin
				gain_q[chan_q]  <= neg_q ? -$signed(GAIN_W'(div_q)) : $signed(GAIN_W'(div_q));
				valid_q[chan_q] <= 1'b1;
			end
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= diff_cur * gain_q[sel_ch];
		end
	end

	// Working result: clear at accept, fill per phase
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			temp0_q  <= '0;
			temp1_q  <= '0;
			reject_q <= 1'b0;
		end else begin
			if (cmd.sat && !cmd.rd_ch) begin
				temp0_q <= sat_val;
			end
			if (cmd.sat && cmd.rd_ch) begin
				temp1_q <= sat_val;
			end
			if (cmd.reject) begin
				reject_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_first_q  <= temp0_q;
			out_second_q <= temp1_q;
			out_status_q <= reject_q;
		end
	end

	tac_div #(
		.DVD_W(HUNDRED_W),
		.DVS_W(AVG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (HUNDRED_Q),
		.divisor  (diff_mag),
		.done     (div_done),
		.quotient (div_q)
	);

	assign st.diff_zero = (diff_cur == '0);
	assign st.div_done  = div_done;
	assign temp_first   = out_first_q;
	assign temp_second  = out_second_q;
	assign status       = out_status_q;

endmodule

`default_nettype wire

/* rtl/tac_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tac_ctrl
// Sequencer of the core: accepts one request at a time, steps the datapath
// through the phases of its kind and hands any result to the output register.
// ----------------------------------------------------------------------------
module tac_ctrl import tac_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  kind,
	input  wire logic        out_ready,
	input  wire stat_t       st,
	output logic             in_ready,
	output logic             out_valid,
	output cmd_t             cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (kind_t'(kind))
						KIND_SAMPLE:  state_d = ST_SMP_UPD;
						KIND_READ:    state_d = ST_RD_MUL0;
						KIND_ZERO:    state_d = ST_CAP_ZERO;
						KIND_HUNDRED: state_d = ST_CAP_DIFF;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_SMP_UPD:  state_d = ST_IDLE;
			ST_RD_MUL0:  state_d = ST_RD_SAT0;
			ST_RD_SAT0:  state_d = ST_RD_MUL1;
			ST_RD_MUL1:  state_d = ST_RD_SAT1;
			ST_RD_SAT1:  state_d = ST_RESP;
			ST_CAP_ZERO: state_d = ST_RESP;
			ST_CAP_DIFF: state_d = st.diff_zero ? ST_RESP : ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (st.div_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SMP_UPD: cmd.smp_upd = 1'b1;
			ST_RD_MUL0: cmd.mul = 1'b1;
			ST_RD_SAT0: cmd.sat = 1'b1;
			ST_RD_MUL1: begin
				cmd.mul   = 1'b1;
				cmd.rd_ch = 1'b1;
			end
			ST_RD_SAT1: begin
				cmd.sat   = 1'b1;
				cmd.rd_ch = 1'b1;
			end
			ST_CAP_ZERO: begin
				cmd.cap_sel  = 1'b1;
				cmd.cap_zero = 1'b1;
			end
			ST_CAP_DIFF: begin
				cmd.cap_sel   = 1'b1;
				cmd.reject    = st.diff_zero;
				cmd.div_start = !st.diff_zero;
			end
			ST_DIV_WAIT: begin
				cmd.cap_sel    = 1'b1;
				cmd.gain_write = st.div_done;
			end
			ST_RESP: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/thermocouple_average_calibrate_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thermocouple_average_calibrate_core
// Two-channel moving average over a WINDOW-deep ring with two-point linear
// calibration per channel.
// ----------------------------------------------------------------------------
// The core takes one request at a time. A sample request is accepted, then
// the ring is written and the sums updated (the ring is a single memory read
// at accept and written the next cycle). A read request steps through
// accept, the one multiplier used for channel 0 and then channel 1, each
// followed by a saturate step, then the hand-off to the output register.
// A zero-point capture stores the offset, then hands off. A hundred-point
// capture waits on the 31-step gain divider; with equal readings it skips
// the divider. Results sit in an output register, so sample requests keep
// flowing while a result waits to be taken. The ring needs no clearing pass
// after reset: until the write pointer first wraps, old entries read as zero.
// ----------------------------------------------------------------------------
module thermocouple_average_calibrate_core import tac_pkg::*; #(
	parameter int WINDOW      = 64,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             kind,
	input  wire logic                   channel,
	input  wire logic [SAMPLE_BITS-1:0] sample_first,
	input  wire logic [SAMPLE_BITS-1:0] sample_second,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [TEMP_W-1:0]           temp_first,
	output logic [TEMP_W-1:0]           temp_second,
	output logic                        status
);

	cmd_t  cmd;
	stat_t st;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	tac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_ready (out_ready),
		.st        (st),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	tac_datapath #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.channel       (channel),
		.sample_first  (sample_first),
		.sample_second (sample_second),
		.temp_first    (temp_first),
		.temp_second   (temp_second),
		.status        (status)
	);

	// Every request kind leaves the idle state in the cycle after its accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted on back-to-back cycles");

	// A sample request never raises a result
	a_sample_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_SAMPLE && !out_valid |=> !out_valid)
		else $error("sample request produced a result");

	// A rejected calibration reports zero temperatures
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> temp_first == '0 && temp_second == '0)
		else $error("reject status with nonzero temperatures");

endmodule

`default_nettype wire
